// ===== hw/rtl/sha1_message_digest_core_macros.svh =====
// Assertion macros shared by the SHA-1 digest core checker.
`ifndef SHA1_MESSAGE_DIGEST_CORE_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, switched off while rst_n is low.
`define SHA1MD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, switched off while rst_n is low.
`define SHA1MD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sha1md_pkg.sv =====
// Shared types, constants and round functions of the SHA-1 digest core.
`timescale 1ns / 1ps
`default_nettype none
package sha1md_pkg;

  // Default depth of the queue between front and back end (power of two).
  localparam int QUEUE_DEPTH_DEF = 4;

  // One classified byte on its way to the back end.
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } cmd_t;

  typedef logic [4:0][31:0] word5_t;

  localparam word5_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                               32'hEFCDAB89, 32'h67452301};

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Rounds are numbered 0..79; these bound the four stages.
  localparam logic [6:0] RND_STAGE1 = 7'd20;
  localparam logic [6:0] RND_STAGE2 = 7'd40;
  localparam logic [6:0] RND_STAGE3 = 7'd60;
  localparam logic [6:0] RND_LAST   = 7'd79;

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] x);
    return {x[1:0], x[31:2]};
  endfunction

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  // Round function of the stage that round t belongs to.
  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t < RND_STAGE1) begin
      f = (b & c) | (~b & d);
    end else if (t < RND_STAGE2) begin
      f = b ^ c ^ d;
    end else if (t < RND_STAGE3) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < RND_STAGE1) begin
      k = K_R0;
    end else if (t < RND_STAGE2) begin
      k = K_R1;
    end else if (t < RND_STAGE3) begin
      k = K_R2;
    end else begin
      k = K_R3;
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sha1md_fifo.sv =====
// Short queue of classified bytes between the front and back end.
`timescale 1ns / 1ps
`default_nettype none
module sha1md_fifo #(
  parameter int DEPTH = sha1md_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire sha1md_pkg::cmd_t push_cmd,
  output logic                  full,
  input  wire logic             pop,
  output sha1md_pkg::cmd_t      pop_cmd,
  output logic                  not_empty
);

  localparam int AW = $clog2(DEPTH);

  sha1md_pkg::cmd_t mem_r [DEPTH];
  logic [AW:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW:0] rd_ptr_r, rd_ptr_nxt;

  // Pointers carry one extra bit so that full and empty differ.
  assign full      = (wr_ptr_r[AW] != rd_ptr_r[AW]) &&
                     (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign not_empty = (wr_ptr_r != rd_ptr_r);
  assign pop_cmd   = mem_r[rd_ptr_r[AW-1:0]];

  assign wr_ptr_nxt = wr_ptr_r + (AW+1)'(push);
  assign rd_ptr_nxt = rd_ptr_r + (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r[AW-1:0]] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sha1md_front.sv =====
// Input stage: takes bytes from the input channel and forms queue commands.
`timescale 1ns / 1ps
`default_nettype none
module sha1md_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_final_byte,
  output logic             push,
  output sha1md_pkg::cmd_t push_cmd,
  input  wire logic        q_full
);

  logic             held_r, held_nxt;
  sha1md_pkg::cmd_t cmd_r;
  logic             take;

  // The holding register drains into the queue whenever there is room.
  assign push     = held_r && !q_full;
  assign push_cmd = cmd_r;
  assign in_stall = held_r && q_full;
  assign take     = in_valid && !in_stall;

  always_comb begin
    held_nxt = held_r;
    if (take) begin
      held_nxt = 1'b1;
    end else if (push) begin
      held_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r.data <= in_data_byte;
      cmd_r.last <= in_final_byte;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sha1md_back.sv =====
// Back end: block packing, padding, the 80-round compression and the digest register.
`timescale 1ns / 1ps
`default_nettype none
module sha1md_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_not_empty,
  input  wire sha1md_pkg::cmd_t q_cmd,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [31:0]           out_digest_w0,
  output logic [31:0]           out_digest_w1,
  output logic [31:0]           out_digest_w2,
  output logic [31:0]           out_digest_w3,
  output logic [31:0]           out_digest_w4
);

  typedef enum logic [3:0] {
    ST_FETCH = 4'b0001,
    ST_PAD   = 4'b0010,
    ST_COMP  = 4'b0100,
    ST_ADD   = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [5:0]          pos_r, pos_nxt;
  logic [63:0]         msg_bits_r, msg_bits_nxt;
  sha1md_pkg::word5_t  chain_r, chain_nxt;
  sha1md_pkg::word5_t  vars_r, vars_nxt;
  logic [6:0]          round_r, round_nxt;
  logic                fin_r, fin_nxt;
  logic                len_ok_r, len_ok_nxt;
  logic                pad80_r, pad80_nxt;
  logic [15:0][31:0]   sched_r, sched_nxt;
  logic                out_valid_r, out_valid_nxt;
  sha1md_pkg::word5_t  digest_r;
  logic                digest_load;

  sha1md_pkg::word5_t  sums;
  logic                out_free;
  logic [7:0]          pad_byte;
  logic [7:0]          len_byte;
  logic [31:0]         round_tmp;
  logic [31:0]         sched_new;

  // Word 15 of the schedule window is the oldest word, w[t].
  assign sched_new = sha1md_pkg::rotl1(sched_r[2] ^ sched_r[7] ^ sched_r[13] ^ sched_r[15]);
  assign round_tmp = sha1md_pkg::rotl5(vars_r[0])
                   + sha1md_pkg::round_f(round_r, vars_r[1], vars_r[2], vars_r[3])
                   + vars_r[4] + sha1md_pkg::round_k(round_r) + sched_r[15];

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      sums[i] = chain_r[i] + vars_r[i];
    end
  end

  assign len_byte = 8'(msg_bits_r >> {~pos_r[2:0], 3'b000});

  always_comb begin
    if (pad80_r) begin
      pad_byte = sha1md_pkg::PAD_MARK;
    end else if (len_ok_r && (pos_r >= 6'd56)) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == ST_FETCH) && q_not_empty;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    msg_bits_nxt  = msg_bits_r;
    chain_nxt     = chain_r;
    vars_nxt      = vars_r;
    round_nxt     = round_r;
    fin_nxt       = fin_r;
    len_ok_nxt    = len_ok_r;
    pad80_nxt     = pad80_r;
    sched_nxt     = sched_r;
    digest_load   = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_FETCH: begin
        if (q_not_empty) begin
          // The whole block shifts up by one byte; the new byte enters at the bottom.
          sched_nxt    = {sched_r[15][23:0], sched_r[14:0], q_cmd.data};
          msg_bits_nxt = msg_bits_r + 64'd8;
          pos_nxt      = pos_r + 6'd1;
          fin_nxt      = q_cmd.last;
          pad80_nxt    = q_cmd.last;
          len_ok_nxt   = 1'b0;
          if (pos_r == 6'd63) begin
            state_nxt = ST_COMP;
            vars_nxt  = chain_r;
            round_nxt = '0;
          end else if (q_cmd.last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        sched_nxt = {sched_r[15][23:0], sched_r[14:0], pad_byte};
        pos_nxt   = pos_r + 6'd1;
        pad80_nxt = 1'b0;
        if (pad80_r && (pos_r <= 6'd55)) begin
          len_ok_nxt = 1'b1;
        end
        if (pos_r == 6'd63) begin
          state_nxt = ST_COMP;
          vars_nxt  = chain_r;
          round_nxt = '0;
        end
      end
      ST_COMP: begin
        vars_nxt  = {vars_r[3], vars_r[2], sha1md_pkg::rotl30(vars_r[1]), vars_r[0],
                     round_tmp};
        sched_nxt = {sched_r[14:0], sched_new};
        round_nxt = round_r + 7'd1;
        if (round_r == sha1md_pkg::RND_LAST) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (fin_r && len_ok_r) begin
          // Final block done: hand the digest over once the output is free.
          if (out_free) begin
            digest_load   = 1'b1;
            out_valid_nxt = 1'b1;
            chain_nxt     = sha1md_pkg::H_INIT;
            msg_bits_nxt  = '0;
            fin_nxt       = 1'b0;
            len_ok_nxt    = 1'b0;
            state_nxt     = ST_FETCH;
          end
        end else if (fin_r) begin
          chain_nxt  = sums;
          len_ok_nxt = 1'b1;
          state_nxt  = ST_PAD;
        end else begin
          chain_nxt = sums;
          state_nxt = ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FETCH;
      pos_r       <= '0;
      msg_bits_r  <= '0;
      chain_r     <= sha1md_pkg::H_INIT;
      round_r     <= '0;
      fin_r       <= 1'b0;
      len_ok_r    <= 1'b0;
      pad80_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      msg_bits_r  <= msg_bits_nxt;
      chain_r     <= chain_nxt;
      round_r     <= round_nxt;
      fin_r       <= fin_nxt;
      len_ok_r    <= len_ok_nxt;
      pad80_r     <= pad80_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sched_r <= sched_nxt;
    vars_r  <= vars_nxt;
    if (digest_load) begin
      digest_r <= sums;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_digest_w0 = digest_r[0];
  assign out_digest_w1 = digest_r[1];
  assign out_digest_w2 = digest_r[2];
  assign out_digest_w3 = digest_r[3];
  assign out_digest_w4 = digest_r[4];

endmodule
`default_nettype wire

// ===== hw/rtl/sha1_message_digest_core.sv =====
// Top level of the SHA-1 message digest core.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+------------------------------------
//   in      | input     | in_valid/in_stall  | in_data_byte, in_final_byte
//   out     | output    | out_valid/out_stall| out_digest_w0 .. out_digest_w4
//
// Each message byte takes a fetch step in the back end; every full 64-byte block then
// takes 80 rounds of the single round unit plus one chaining add, and the back end
// takes no new byte while it compresses a block.
// The final item adds a padding step per padding byte and one or two more compressions.
// Reset (rst_n low at a clock edge) loads the initial hash values and clears the queue.
// in_stall rises only when the holding register and the queue are both full; a stalled
// digest holds on the out_ ports while the back end keeps working up to its next digest.
`timescale 1ns / 1ps
`default_nettype none
module sha1_message_digest_core #(
  parameter int QUEUE_DEPTH = sha1md_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_final_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_w0,
  output logic [31:0]      out_digest_w1,
  output logic [31:0]      out_digest_w2,
  output logic [31:0]      out_digest_w3,
  output logic [31:0]      out_digest_w4
);

  // Front end to queue.
  logic             push;
  sha1md_pkg::cmd_t push_cmd;
  logic             q_full;

  // Queue to back end.
  logic             q_pop;
  sha1md_pkg::cmd_t q_cmd;
  logic             q_not_empty;

  // The front end registers each accepted item and tags it with its final flag.
  sha1md_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .push          (push),
    .push_cmd      (push_cmd),
    .q_full        (q_full)
  );

  // The queue lets the front end keep taking items while the back end compresses.
  sha1md_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (q_cmd),
    .not_empty (q_not_empty)
  );

  // The back end packs bytes into the block, pads, compresses and owns the digest.
  sha1md_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_digest_w0 (out_digest_w0),
    .out_digest_w1 (out_digest_w1),
    .out_digest_w2 (out_digest_w2),
    .out_digest_w3 (out_digest_w3),
    .out_digest_w4 (out_digest_w4)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/sha1md_checker.sv =====
// Port-level checker for the SHA-1 digest core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sha1_message_digest_core_macros.svh"
module sha1md_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_final_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_digest_w0,
  input wire logic [31:0] out_digest_w1,
  input wire logic [31:0] out_digest_w2,
  input wire logic [31:0] out_digest_w3,
  input wire logic [31:0] out_digest_w4
);

  logic       in_take;
  logic       out_take;
  logic       in_last;
  logic [7:0] pend_r, pend_nxt;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_last  = in_take && in_final_byte;

  // Messages whose final item has been taken but whose digest is not yet out.
  assign pend_nxt = pend_r + 8'(in_last) - 8'(out_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `SHA1MD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_digest_w0) && $stable(out_digest_w1) &&
    $stable(out_digest_w2) && $stable(out_digest_w3) && $stable(out_digest_w4),
    "digest changed or vanished while stalled")
  `SHA1MD_ASSERT_SAME(a_out_has_msg, out_take, pend_r != 8'd0,
    "digest delivered without a finished message")
  `SHA1MD_ASSERT_NEXT(a_no_instant_digest, in_last && (pend_r == 8'd0) && !out_valid,
    !out_valid, "digest appeared one cycle after the final item")
  `SHA1MD_ASSERT_SAME(a_pend_bound, 1'b1, pend_r != 8'hFF,
    "outstanding message count ran away")

endmodule

bind sha1_message_digest_core sha1md_checker u_sha1md_checker (.*);
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the SHA-1 message digest core.
`timescale 1ns / 1ps
`default_nettype none
module tb;

  // The five digest words of one message, w0 the most significant.
  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [31:0] w4;
  } digest_t;

  // Standard initial hash values and the round constants of the four stages.
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;
  localparam logic [31:0] KC0 = 32'h5A827999;
  localparam logic [31:0] KC1 = 32'h6ED9EBA1;
  localparam logic [31:0] KC2 = 32'h8F1BBCDC;
  localparam logic [31:0] KC3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  // The digest of the three-byte message "abc", from the SHA-1 standard.
  localparam digest_t ABC_DIGEST = '{32'hA9993E36, 32'h4706816A, 32'hBA3E2571,
                                     32'h7850C26C, 32'h9CD0D89D};

  // Run limit in clock cycles. The slowest correct run sends about 850 bytes
  // with random gaps, some thirty digests of up to three compressions each,
  // and receiver stalls on top.
  localparam int CYCLE_LIMIT  = 300000;
  // Cycles allowed after the last digest before the verdict.
  localparam int DRAIN_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_final_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_w0;
  logic [31:0] out_digest_w1;
  logic [31:0] out_digest_w2;
  logic [31:0] out_digest_w3;
  logic [31:0] out_digest_w4;

  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int in_idle_pct = 0;
  int out_idle_pct = 0;

  int fail_count = 0;
  int cycle_count = 0;

  // Predicted digests, oldest first, waiting for the core to deliver them.
  digest_t expected_digests[$];
  digest_t last_predicted;

  // Predictor state: chaining words, the block being filled, and the
  // running message length in bits.
  logic [31:0] hash_state[5];
  logic [31:0] blk_words[16];
  logic [63:0] msg_bit_count;

  // Message lengths around the padding boundaries: 55 bytes is the longest
  // message whose padding fits in one block, 56 forces a second block, and
  // multiples of 64 fill a block exactly before the padding starts.
  int boundary_lens[13] = '{55, 56, 57, 63, 64, 65, 66, 119, 120, 121, 127, 128, 129};

  sha1_message_digest_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_digest_w0 (out_digest_w0),
    .out_digest_w1 (out_digest_w1),
    .out_digest_w2 (out_digest_w2),
    .out_digest_w3 (out_digest_w3),
    .out_digest_w4 (out_digest_w4)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a hung core or a digest that never shows up ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** sha1_message_digest_core: FAILED **");
      $finish;
    end
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic logic [31:0] rotate_left(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void load_initial_hash();
    hash_state[0] = IV0;
    hash_state[1] = IV1;
    hash_state[2] = IV2;
    hash_state[3] = IV3;
    hash_state[4] = IV4;
    msg_bit_count = 64'd0;
  endfunction

  // Bytes are packed big-endian: the first byte of each group of four lands
  // in the top of the word and clears the rest of it.
  function automatic void place_byte(input logic [5:0] pos, input logic [7:0] b);
    logic [31:0] shifted;
    shifted = {24'd0, b} << ((3 - pos[1:0]) * 8);
    if (pos[1:0] == 2'd0) begin
      blk_words[pos[5:2]] = shifted;
    end else begin
      blk_words[pos[5:2]] = blk_words[pos[5:2]] | shifted;
    end
  endfunction

  // One 80-round compression of the current block into the chaining words.
  function automatic void compress_block();
    logic [31:0] sched[16];
    logic [31:0] a, b, c, d, e, f, k, wt, tmp;
    for (int i = 0; i < 16; i++) sched[i] = blk_words[i];
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = sched[t];
      end else begin
        wt = rotate_left(sched[(t - 3) & 15] ^ sched[(t - 8) & 15] ^
                         sched[(t - 14) & 15] ^ sched[t & 15], 1);
        sched[t & 15] = wt;
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = KC0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = KC1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = KC2;
      end else begin
        f = b ^ c ^ d;
        k = KC3;
      end
      tmp = rotate_left(a, 5) + f + e + k + wt;
      e = d;
      d = c;
      c = rotate_left(b, 30);
      b = a;
      a = tmp;
    end
    hash_state[0] = hash_state[0] + a;
    hash_state[1] = hash_state[1] + b;
    hash_state[2] = hash_state[2] + c;
    hash_state[3] = hash_state[3] + d;
    hash_state[4] = hash_state[4] + e;
  endfunction

  // Takes one accepted byte. Returns 1 with the digest when the byte ends
  // the message; the chaining words then go back to their initial values.
  function automatic bit absorb_byte(input logic [7:0] b, input logic fin,
                                     output digest_t dg);
    int pos;
    pos = msg_bit_count[8:3];
    place_byte(pos[5:0], b);
    msg_bit_count = msg_bit_count + 64'd8;
    pos++;
    if (pos == 64) begin
      compress_block();
      pos = 0;
    end
    dg = '0;
    if (!fin) return 1'b0;

    place_byte(pos[5:0], PAD_BYTE);
    pos++;
    // No room left for the length field: close this block with zeros.
    if (pos > 56) begin
      while (pos < 64) begin
        place_byte(pos[5:0], 8'h00);
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < 56) begin
      place_byte(pos[5:0], 8'h00);
      pos++;
    end
    blk_words[14] = msg_bit_count[63:32];
    blk_words[15] = msg_bit_count[31:0];
    compress_block();
    dg = '{hash_state[0], hash_state[1], hash_state[2], hash_state[3], hash_state[4]};
    load_initial_hash();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------

  // Offers one byte and returns at the edge where the core takes it. Valid
  // is left high on return, so a following call either presents the next
  // item or drops valid for a gap, never both in one time step.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    digest_t dg;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (absorb_byte(b, fin, dg)) begin
      expected_digests.insert(expected_digests.size(), dg);
      last_predicted = dg;
    end
  endtask

  task automatic check_word(input string field, input logic [31:0] expv,
                            input logic [31:0] actv);
    if (actv !== expv) begin
      $error("%s mismatch: expected %08h, got %08h", field, expv, actv);
      fail_count++;
    end
  endtask

  // Each digest the core hands over is matched against the oldest prediction.
  always @(posedge clk) begin : digest_checker
    digest_t expd;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_digests.size() == 0) begin
        $error("digest delivered with no message pending: %08h %08h %08h %08h %08h",
               out_digest_w0, out_digest_w1, out_digest_w2, out_digest_w3,
               out_digest_w4);
        fail_count++;
      end else begin
        expd = expected_digests.pop_front();
        check_word("digest_w0", expd.w0, out_digest_w0);
        check_word("digest_w1", expd.w1, out_digest_w1);
        check_word("digest_w2", expd.w2, out_digest_w2);
        check_word("digest_w3", expd.w3, out_digest_w3);
        check_word("digest_w4", expd.w4, out_digest_w4);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // One-byte messages at both extremes of the byte, then a two-byte message
  // with alternating bit patterns so every data bit toggles.
  task automatic test_byte_extremes();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
  endtask

  // The standard "abc" vector. The predictor is held to the published
  // digest here, so an error in it cannot hide behind a matching core.
  task automatic test_known_vector();
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b1);
    if (last_predicted !== ABC_DIGEST) begin
      $error("digest_w0..w4 of \"abc\": expected %040h, predicted %040h",
             ABC_DIGEST, last_predicted);
      fail_count++;
    end
  endtask

  // The same message twice in a row must give the same digest, which shows
  // that the chaining words and the length count go back to their initial
  // values after a digest.
  task automatic test_state_clears();
    for (int rep = 0; rep < 2; rep++) begin
      send_byte(8'hDE, 1'b0);
      send_byte(8'hAD, 1'b0);
      send_byte(8'hBE, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'h01, 1'b1);
    end
  endtask

  // Mostly short messages, a good share of lengths on the padding
  // boundaries, and the rest spread up to a little over two blocks.
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(16, 1);
    if (r < 90) return boundary_lens[$urandom_range(12)];
    return $urandom_range(150, 1);
  endfunction

  // Random messages until both the byte budget and the digest floor are met.
  // Some messages are all zeros or all ones to stress the schedule words.
  task automatic test_random_messages(input int byte_budget, input int digest_floor);
    int sent;
    int done;
    int len;
    int pattern;
    logic [7:0] b;
    sent = 0;
    done = 0;
    while (sent < byte_budget || done < digest_floor) begin
      len = pick_length();
      pattern = $urandom_range(9);
      for (int i = 0; i < len; i++) begin
        if (pattern == 0) begin
          b = 8'h00;
        end else if (pattern == 1) begin
          b = 8'hFF;
        end else begin
          b = $urandom_range(255);
        end
        send_byte(b, i == len - 1);
      end
      sent += len;
      done++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    load_initial_hash();
    for (int i = 0; i < 16; i++) blk_words[i] = 32'd0;

    // Synchronous reset, held low before the first test.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First phase: the sender idles now and then, the receiver often.
    in_idle_pct  = 38;
    out_idle_pct = 66;
    test_byte_extremes();
    test_known_vector();
    test_state_clears();
    test_random_messages(240, 5);

    // Second phase: the roles swap, so the input side backs up less and
    // the core more often waits for bytes in the middle of a block.
    in_idle_pct  = 66;
    out_idle_pct = 38;
    test_random_messages(240, 5);

    // Third phase: full rate on both sides.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_messages(240, 5);

    // Every byte is in; let the remaining digests come out.
    in_valid <= 1'b0;
    while (expected_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("** sha1_message_digest_core: PASSED **");
    end else begin
      $display("** sha1_message_digest_core: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
